// ===== src/gda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Gregorian date advance block.
// Used by gda_mod400, gda_date_step and gregorian_date_advance; no dependencies.
package gda_pkg;

   localparam int unsigned REM_BITS     = 9;
   localparam int unsigned YEARS_CYCLE  = 400;
   localparam int unsigned YEARS_CENT   = 100;
   localparam int unsigned LAST_MONTH   = 12;
   localparam int unsigned MONTH_FEB    = 2;
   localparam int unsigned MONTH_APR    = 4;
   localparam int unsigned MONTH_JUN    = 6;
   localparam int unsigned MONTH_SEP    = 9;
   localparam int unsigned MONTH_NOV    = 11;
   localparam int unsigned DAYS_LONG    = 31;
   localparam int unsigned DAYS_SHORT   = 30;
   localparam int unsigned DAYS_FEB     = 28;
   localparam int unsigned DAYS_FEB_LEAP = 29;

   // Reciprocal of 400 rounded up and scaled by two to the power REM_SHIFT.
   localparam int unsigned REM_MAGIC    = 32'h51EB851F;
   localparam int unsigned REM_SHIFT    = 39;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_STEP,
      ST_DONE
   } gda_state_type;

   typedef struct packed {
      logic date_valid;
      logic month_end;
      logic year_end;
      logic overflow;
   } gda_step_status_type;

endpackage

// ===== src/gda_mod400.sv =====
`timescale 1ns / 1ps
// Remainder of the year by 400 by reciprocal multiplication and multiply-back.
// Depends on gda_pkg.
module gda_mod400 #(
   parameter int unsigned YEAR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [YEAR_BITS-1:0]          year,
   output logic [gda_pkg::REM_BITS-1:0]  rem,
   output logic                          done
);

   localparam int unsigned PROD_W = 63;
   localparam int unsigned QUO_W  = PROD_W - gda_pkg::REM_SHIFT;

   logic [1:0]                    cnt_ff;
   logic [YEAR_BITS-1:0]          yr_ff;
   logic [QUO_W-1:0]              quo_ff;
   logic [gda_pkg::REM_BITS-1:0]  rem_ff;
   logic [31:0]                   yr_wide;
   logic [PROD_W-1:0]             prod;
   logic [31:0]                   back;
   logic [31:0]                   diff;
   logic [QUO_W-1:0]              quo_in;
   logic [gda_pkg::REM_BITS-1:0]  rem_in;

   // With the constant rounded up, the shifted product is the exact quotient
   // for every year of up to 32 bits, so the difference always fits in nine bits.
   always_comb begin
      yr_wide = 32'(yr_ff);
      prod    = PROD_W'(yr_wide) * PROD_W'(gda_pkg::REM_MAGIC);
      quo_in  = prod[PROD_W-1:gda_pkg::REM_SHIFT];
      back    = 32'(quo_ff) * 32'(gda_pkg::YEARS_CYCLE);
      diff    = yr_wide - back;
      rem_in  = diff[gda_pkg::REM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= 2'd2;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // The quotient is registered first and the remainder after it, from that quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         yr_ff <= year;
      end
      if (cnt_ff == 2'd2) begin
         quo_ff <= quo_in;
      end
      if (cnt_ff == 2'd1) begin
         rem_ff <= rem_in;
      end
   end

   assign rem  = rem_ff;
   assign done = (cnt_ff == '0);

endmodule

// ===== src/gda_date_step.sv =====
`timescale 1ns / 1ps
// Month length, date check and the one-day step of the current date.
// Depends on gda_pkg.
module gda_date_step #(
   parameter int unsigned YEAR_BITS = 16
) (
   input  logic [4:0]                      day,
   input  logic [3:0]                      month,
   input  logic [YEAR_BITS-1:0]            year,
   input  logic [gda_pkg::REM_BITS-1:0]    year_rem,
   output logic [4:0]                      next_day,
   output logic [3:0]                      next_month,
   output logic [YEAR_BITS-1:0]            next_year,
   output logic [gda_pkg::REM_BITS-1:0]    next_rem,
   output gda_pkg::gda_step_status_type    status
);

   logic       century;
   logic       leap;
   logic [4:0] month_len;

   always_comb begin
      // Year remainder by 400 tells both the century and the 400-year rule.
      century = (year_rem == gda_pkg::REM_BITS'(0))
             || (year_rem == gda_pkg::REM_BITS'(gda_pkg::YEARS_CENT))
             || (year_rem == gda_pkg::REM_BITS'(2 * gda_pkg::YEARS_CENT))
             || (year_rem == gda_pkg::REM_BITS'(3 * gda_pkg::YEARS_CENT));
      leap = ((year[1:0] == 2'b00) && !century)
          || (year_rem == gda_pkg::REM_BITS'(0));

      if (month == 4'(gda_pkg::MONTH_FEB)) begin
         month_len = leap ? 5'(gda_pkg::DAYS_FEB_LEAP) : 5'(gda_pkg::DAYS_FEB);
      end else if ((month == 4'(gda_pkg::MONTH_APR)) || (month == 4'(gda_pkg::MONTH_JUN))
                || (month == 4'(gda_pkg::MONTH_SEP)) || (month == 4'(gda_pkg::MONTH_NOV))) begin
         month_len = 5'(gda_pkg::DAYS_SHORT);
      end else begin
         month_len = 5'(gda_pkg::DAYS_LONG);
      end

      status.date_valid = (month != 4'd0) && (month <= 4'(gda_pkg::LAST_MONTH))
                       && (day != 5'd0) && (day <= month_len);
      status.month_end  = (day >= month_len);
      status.year_end   = status.month_end && (month >= 4'(gda_pkg::LAST_MONTH));
      status.overflow   = status.year_end && (year == '1);

      next_day   = day;
      next_month = month;
      next_year  = year;
      next_rem   = year_rem;
      if (!status.month_end) begin
         next_day = day + 5'd1;
      end else if (!status.year_end) begin
         next_day   = 5'd1;
         next_month = month + 4'd1;
      end else if (!status.overflow) begin
         next_day   = 5'd1;
         next_month = 4'd1;
         next_year  = year + YEAR_BITS'(1);
         if (year_rem == gda_pkg::REM_BITS'(gda_pkg::YEARS_CYCLE - 1)) begin
            next_rem = '0;
         end else begin
            next_rem = year_rem + gda_pkg::REM_BITS'(1);
         end
      end
   end

endmodule

// ===== src/gregorian_date_advance.sv =====
`timescale 1ns / 1ps
// Top level of the Gregorian date advance block: sequencer, date registers, count.
// Depends on gda_pkg, gda_mod400 and gda_date_step.

// The block takes one item at a time and answers it with one result item.
// After acceptance the remainder-by-400 unit sets up the leap-year rule: a
// reciprocal multiplication, a multiply-back and subtract, and then its
// report of done. The start date is checked next, and the date step unit
// then advances the date one day at a time until the count runs out, before
// the result is offered. An invalid start date goes straight to the result
// after the check, and a year overflow ends the stepping early. The block is
// not ready for the next item until the result has been taken; it is ready
// again in the cycle after that.
module gregorian_date_advance #(
   parameter int unsigned YEAR_BITS  = 16,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [4:0]             req_start_day,
   input  logic [3:0]             req_start_month,
   input  logic [YEAR_BITS-1:0]   req_start_year,
   input  logic [COUNT_BITS-1:0]  req_days_ahead,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_result_day,
   output logic [3:0]             rsp_result_month,
   output logic [YEAR_BITS-1:0]   rsp_result_year,
   output logic                   rsp_date_error
);

   gda_pkg::gda_state_type state_ff, state_in;

   logic [4:0]                      day_ff,   day_in;
   logic [3:0]                      month_ff, month_in;
   logic [YEAR_BITS-1:0]            year_ff,  year_in;
   logic [gda_pkg::REM_BITS-1:0]    rem_ff,   rem_in;
   logic [COUNT_BITS-1:0]           cnt_ff,   cnt_in;
   logic                            err_ff,   err_in;

   logic                            mod_start;
   logic                            mod_done;
   logic [gda_pkg::REM_BITS-1:0]    mod_rem;
   logic [gda_pkg::REM_BITS-1:0]    step_rem;
   logic [4:0]                      nx_day;
   logic [3:0]                      nx_month;
   logic [YEAR_BITS-1:0]            nx_year;
   logic [gda_pkg::REM_BITS-1:0]    nx_rem;
   gda_pkg::gda_step_status_type    step_status;

   gda_mod400 #(.YEAR_BITS(YEAR_BITS)) u_mod400 (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .year  (req_start_year),
      .rem   (mod_rem),
      .done  (mod_done)
   );

   // During the check the remainder comes fresh from the remainder unit.
   assign step_rem = (state_ff == gda_pkg::ST_CHECK) ? mod_rem : rem_ff;

   gda_date_step #(.YEAR_BITS(YEAR_BITS)) u_step (
      .day        (day_ff),
      .month      (month_ff),
      .year       (year_ff),
      .year_rem   (step_rem),
      .next_day   (nx_day),
      .next_month (nx_month),
      .next_year  (nx_year),
      .next_rem   (nx_rem),
      .status     (step_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
   end

   always_comb begin
      state_in  = state_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      mod_start = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         gda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mod_start = 1'b1;
               day_in    = req_start_day;
               month_in  = req_start_month;
               year_in   = req_start_year;
               cnt_in    = req_days_ahead;
               err_in    = 1'b0;
               state_in  = gda_pkg::ST_MOD;
            end
         end
         gda_pkg::ST_MOD: begin
            if (mod_done) begin
               state_in = gda_pkg::ST_CHECK;
            end
         end
         gda_pkg::ST_CHECK: begin
            rem_in = mod_rem;
            if (!step_status.date_valid) begin
               err_in   = 1'b1;
               state_in = gda_pkg::ST_DONE;
            end else begin
               state_in = gda_pkg::ST_STEP;
            end
         end
         gda_pkg::ST_STEP: begin
            if (cnt_ff == '0) begin
               state_in = gda_pkg::ST_DONE;
            end else if (step_status.overflow) begin
               err_in   = 1'b1;
               state_in = gda_pkg::ST_DONE;
            end else begin
               day_in   = nx_day;
               month_in = nx_month;
               year_in  = nx_year;
               rem_in   = nx_rem;
               cnt_in   = cnt_ff - COUNT_BITS'(1);
            end
         end
         gda_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = gda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gda_pkg::ST_IDLE;
         end
      endcase
   end

   // On error every date field of the result item reads as zero.
   assign rsp_result_day   = err_ff ? 5'd0 : day_ff;
   assign rsp_result_month = err_ff ? 4'd0 : month_ff;
   assign rsp_result_year  = err_ff ? '0 : year_ff;
   assign rsp_date_error   = err_ff;

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready and result valid high together");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_error) |->
         (rsp_result_day == 5'd0) && (rsp_result_month == 4'd0) && (rsp_result_year == '0))
      else $error("error result carries a non-zero date");

   a_result_valid_date : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_date_error) |->
         (rsp_result_day != 5'd0) && (rsp_result_month != 4'd0)
         && (rsp_result_month <= 4'(gda_pkg::LAST_MONTH)))
      else $error("good result carries an impossible date");

   a_step_after_check : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_CHECK) |-> mod_done)
      else $error("date check started before the remainder was ready");

endmodule
